[rtl/fcfs_pkg.sv]
// Shared widths and control types for the first-come-first-served scheduler.
`default_nettype none
package fcfs_pkg;

	localparam int unsigned ARR_W  = 16;
	localparam int unsigned TIME_W = 22;
	localparam int unsigned SUM_W  = 27;
	localparam int unsigned PIDX_W = 5;

	// Control from the sequencer to the earliest-arrival compare unit
	typedef struct packed {
		logic clear;  // start a fresh scan
		logic valid;  // candidate on the compare inputs is unserved and loaded
	} pick_ctrl_t;

endpackage
`default_nettype wire

[rtl/fcfs_pick.sv]
// Earliest-arrival compare unit: keeps the best candidate seen during one scan.
`default_nettype none
module fcfs_pick #(
	parameter int unsigned IDX_W = 5
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  fcfs_pkg::pick_ctrl_t    ctrl,
	input  wire  [fcfs_pkg::ARR_W-1:0]    cand_arr,
	input  wire  [IDX_W-1:0]              cand_idx,
	output logic [fcfs_pkg::ARR_W-1:0]    best_arr,
	output logic [IDX_W-1:0]              best_idx
);

	logic                        found_q;
	logic [fcfs_pkg::ARR_W-1:0]  best_arr_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic                        take;

	// Strict less-than keeps the lowest index on ties, since the scan runs upward
	assign take = ctrl.valid && (!found_q || (cand_arr < best_arr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctrl.clear && take) begin
			best_arr_q <= cand_arr;
			best_idx_q <= cand_idx;
		end
	end

	assign best_arr = best_arr_q;
	assign best_idx = best_idx_q;

endmodule
`default_nettype wire

[rtl/fcfs_schedule_timing.sv]
// Top level of the first-come-first-served scheduler: process store and sequencer.
`default_nettype none
// Usage
//   Item channel (item_valid / item_ready): one process per transfer, carrying
//   arrival_time and burst_time. Processes fill slots in load order; once
//   MAX_PROCS are held, further items are dropped. The transfer with
//   last_process high starts the schedule for the loaded set.
//   Result channel (result_valid / result_ready): one transfer per scheduled
//   process, in schedule order, with start, end, turnaround, waiting and the
//   running totals; last_result marks the final process of the set.
//   Rate: while loading, one item per cycle. Each result takes a scan of
//   every stored entry through the single compare unit reading the arrival
//   memory, a step to compare the last entry, one to close the scan, one
//   burst read, two arithmetic steps and one to load the output register.
//   item_ready is low from the last item until the final result sits in the
//   output register.
//   Stall: a held result holds the sequencer before the next result is loaded;
//   nothing is lost. After the final result the block takes new items at once,
//   even while that result still waits.
//   Reset: clears the set (count, served flags, time, totals) and the output
//   valid; the stores need no clearing as only loaded entries are read.
module fcfs_schedule_timing #(
	parameter int unsigned MAX_PROCS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_ready,
	input  wire  [fcfs_pkg::ARR_W-1:0]       arrival_time,
	input  wire  [fcfs_pkg::ARR_W-1:0]       burst_time,
	input  wire                              last_process,
	output logic                             result_valid,
	input  wire                              result_ready,
	output logic [fcfs_pkg::PIDX_W-1:0]      process_index,
	output logic [fcfs_pkg::TIME_W-1:0]      start_time,
	output logic [fcfs_pkg::TIME_W-1:0]      end_time,
	output logic [fcfs_pkg::TIME_W-1:0]      turnaround,
	output logic [fcfs_pkg::TIME_W-1:0]      waiting,
	output logic                             last_result,
	output logic [fcfs_pkg::SUM_W-1:0]       total_turnaround,
	output logic [fcfs_pkg::SUM_W-1:0]       total_waiting
);

	localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
	localparam int unsigned ARR_W  = fcfs_pkg::ARR_W;
	localparam int unsigned TIME_W = fcfs_pkg::TIME_W;
	localparam int unsigned SUM_W  = fcfs_pkg::SUM_W;
	localparam int unsigned PIDX_W = fcfs_pkg::PIDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_CALC1,
		ST_CALC2,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Process stores
	logic [ARR_W-1:0] arrival_mem [MAX_PROCS];
	logic [ARR_W-1:0] burst_mem   [MAX_PROCS];
	logic [ARR_W-1:0] arr_rd_q;
	logic [ARR_W-1:0] bur_rd_q;

	// Set state
	logic [MAX_PROCS-1:0] served_q;
	logic [CNT_W-1:0]     loaded_count_q;
	logic [TIME_W-1:0]    cur_time_q;
	logic [SUM_W-1:0]     sum_tat_q;
	logic [SUM_W-1:0]     sum_wt_q;

	// Sequencer
	logic [CNT_W-1:0]     scan_ptr_q;
	logic [CNT_W-1:0]     done_cnt_q;
	logic                 rd_pend_q;
	logic                 rd_unserved_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [TIME_W-1:0]    start_q;
	logic [TIME_W-1:0]    end_q;
	logic [TIME_W-1:0]    tat_q;
	logic [TIME_W-1:0]    wt_q;

	// Compare unit
	fcfs_pkg::pick_ctrl_t pick_ctrl;
	logic [ARR_W-1:0]     best_arr;
	logic [IDX_W-1:0]     best_idx;

	logic                 item_xfer;
	logic                 store_ok;
	logic [CNT_W-1:0]     count_next;
	logic                 scan_issue;
	logic                 emit_go;
	logic                 final_proc;
	logic [TIME_W-1:0]    arr_ext;
	logic [TIME_W-1:0]    start_calc;
	logic [IDX_W+PIDX_W-1:0] pidx_ext;

	assign item_ready = (state_q == ST_IDLE);
	assign item_xfer  = item_valid && item_ready;
	assign store_ok   = (loaded_count_q < CNT_W'(MAX_PROCS));
	assign count_next = store_ok ? (loaded_count_q + CNT_W'(1)) : loaded_count_q;
	assign scan_issue = (state_q == ST_SCAN) && (scan_ptr_q < loaded_count_q);
	assign emit_go    = (state_q == ST_EMIT) && (!result_valid || result_ready);
	assign final_proc = ((done_cnt_q + CNT_W'(1)) == loaded_count_q);
	assign arr_ext    = {{(TIME_W-ARR_W){1'b0}}, best_arr};
	assign start_calc = (cur_time_q > arr_ext) ? cur_time_q : arr_ext;
	assign pidx_ext   = {{PIDX_W{1'b0}}, best_idx};

	// Clear the compare unit at every scan start; feed it one candidate a cycle
	assign pick_ctrl = '{
		clear: item_xfer || emit_go,
		valid: (state_q == ST_SCAN) && rd_pend_q && rd_unserved_q
	};

	fcfs_pick #(
		.IDX_W (IDX_W)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (pick_ctrl),
		.cand_arr (arr_rd_q),
		.cand_idx (rd_idx_q),
		.best_arr (best_arr),
		.best_idx (best_idx)
	);

	// Store writes and registered reads
	always_ff @(posedge clk) begin
		if (item_xfer && store_ok) begin
			arrival_mem[loaded_count_q[IDX_W-1:0]] <= arrival_time;
			burst_mem[loaded_count_q[IDX_W-1:0]]   <= burst_time;
		end
		if (scan_issue) begin
			arr_rd_q <= arrival_mem[scan_ptr_q[IDX_W-1:0]];
		end
		if (state_q == ST_FETCH) begin
			bur_rd_q <= burst_mem[best_idx];
		end
	end

	// Datapath registers: no reset needed
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			rd_idx_q      <= scan_ptr_q[IDX_W-1:0];
			rd_unserved_q <= !served_q[scan_ptr_q[IDX_W-1:0]];
		end
		if (state_q == ST_CALC1) begin
			start_q <= start_calc;
			end_q   <= start_calc + {{(TIME_W-ARR_W){1'b0}}, bur_rd_q};
		end
		if (state_q == ST_CALC2) begin
			tat_q <= end_q - arr_ext;
			// turnaround minus burst equals start minus arrival modulo the width
			wt_q  <= start_q - arr_ext;
		end
		if (emit_go) begin
			process_index    <= pidx_ext[PIDX_W-1:0];
			start_time       <= start_q;
			end_time         <= end_q;
			turnaround       <= tat_q;
			waiting          <= wt_q;
			last_result      <= final_proc;
			total_turnaround <= sum_tat_q + {{(SUM_W-TIME_W){1'b0}}, tat_q};
			total_waiting    <= sum_wt_q + {{(SUM_W-TIME_W){1'b0}}, wt_q};
		end
	end

	// Sequencer and set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			served_q       <= '0;
			loaded_count_q <= '0;
			cur_time_q     <= '0;
			sum_tat_q      <= '0;
			sum_wt_q       <= '0;
			scan_ptr_q     <= '0;
			done_cnt_q     <= '0;
			rd_pend_q      <= 1'b0;
			result_valid   <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (emit_go) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						loaded_count_q <= count_next;
						if (last_process) begin
							scan_ptr_q <= '0;
							done_cnt_q <= '0;
							rd_pend_q  <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_pend_q <= scan_issue;
					if (scan_issue) begin
						scan_ptr_q <= scan_ptr_q + CNT_W'(1);
					end else if (!rd_pend_q) begin
						// every entry issued and the last one compared
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CALC1;
				end
				ST_CALC1: begin
					state_q <= ST_CALC2;
				end
				ST_CALC2: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (final_proc) begin
							// set complete: drop it and start afresh
							served_q       <= '0;
							loaded_count_q <= '0;
							cur_time_q     <= '0;
							sum_tat_q      <= '0;
							sum_wt_q       <= '0;
							state_q        <= ST_IDLE;
						end else begin
							served_q[best_idx] <= 1'b1;
							cur_time_q <= end_q;
							sum_tat_q  <= sum_tat_q + {{(SUM_W-TIME_W){1'b0}}, tat_q};
							sum_wt_q   <= sum_wt_q + {{(SUM_W-TIME_W){1'b0}}, wt_q};
							done_cnt_q <= done_cnt_q + CNT_W'(1);
							scan_ptr_q <= '0;
							rd_pend_q  <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
